### src/efpm_pkg.sv
package efpm_pkg;

	// Motor count and frame length
	localparam int MOTORS    = 8;
	localparam int FRAME_LEN = 64;

	localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int POS_W = $clog2(FRAME_LEN + 1);
	localparam int WIN_W = POS_W + 1;

	// Opcodes of an input beat
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_SYNC = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_BOARD_ID    = 3'd0;
	localparam logic [2:0] REG_COUNTS_US   = 3'd1;
	localparam logic [2:0] REG_WRAP_LEVEL  = 3'd2;
	localparam logic [2:0] REG_TIMEOUT     = 3'd3;
	localparam logic [2:0] REG_BLINK_HALF  = 3'd4;
	localparam logic [2:0] REG_SYNC_BLINK  = 3'd5;

	// Register reset values
	localparam logic [2:0]  RST_BOARD_ID   = 3'd0;
	localparam logic [23:0] RST_COUNTS_US  = 24'd128000;
	localparam logic [15:0] RST_WRAP_LEVEL = 16'd39061;
	localparam logic [23:0] RST_TIMEOUT    = 24'd200000;
	localparam logic [22:0] RST_BLINK_HALF = 23'd100000;
	localparam logic [7:0]  RST_SYNC_BLINK = 8'd20;

	// Pulse width mapping, microseconds
	localparam logic [10:0] W_IDLE  = 11'd1000;
	localparam logic [10:0] W_BASE  = 11'd1200;
	localparam logic [17:0] W_SPAN  = 18'd800;
	localparam logic [17:0] W_DIV   = 18'd255;

	localparam logic [23:0] TICK_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic sync;
		logic tick;
	} efpm_evt_t;

	typedef struct packed {
		logic led;
		logic fault;
		logic entering;
	} efpm_status_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [7:0]       value;
		logic             status;
		logic             led;
		logic             fault;
		logic             last;
	} efpm_issue_t;

	// 0 maps to the idle width, otherwise 1200 + v*800/255. The result never
	// leaves 1000..2000, so no clamp is needed. The divide by 255 is done as
	// a multiply by 257/65536, which is low by at most one, then corrected.
	function automatic logic [10:0] value_to_width(input logic [7:0] v);
		logic [17:0] x;
		logic [26:0] xm;
		logic [9:0]  q0;
		logic [17:0] r;
		logic [9:0]  q;
		x  = 18'(v) * W_SPAN;
		xm = 27'(x) + 27'({x, 8'b0});
		q0 = xm[25:16];
		r  = x - 18'({q0, 8'b0}) + 18'(q0);
		q  = (r >= W_DIV) ? q0 + 10'd1 : q0;
		if (v == 8'd0) begin
			return W_IDLE;
		end
		return W_BASE + 11'(q);
	endfunction

endpackage

### src/efpm_frame_store.sv
module efpm_frame_store import efpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             wr,
	input  logic [7:0]       rx_byte,
	input  logic [2:0]       board_id,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [7:0]       rd_value
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       pending_q [MOTORS];
	logic [WIN_W-1:0] pos_ext;
	logic [WIN_W-1:0] win_start;
	logic [WIN_W-1:0] win_end;
	logic [WIN_W-1:0] slot_ext;
	logic             in_win;

	assign pos_ext   = WIN_W'(pos_q);
	assign win_start = WIN_W'(board_id) * WIN_W'(MOTORS);
	assign win_end   = win_start + WIN_W'(MOTORS);
	assign in_win    = (pos_ext >= win_start) && (pos_ext < win_end);
	assign slot_ext  = pos_ext - win_start;
	assign rd_value  = pending_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < MOTORS; i++) begin
				pending_q[i] <= '0;
			end
		end else if (clr) begin
			// restart the frame; stored bytes are kept
			pos_q <= '0;
		end else if (wr) begin
			// hold the position at the frame length once it gets there
			if (pos_q < POS_W'(FRAME_LEN)) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (in_win) begin
				pending_q[slot_ext[IDX_W-1:0]] <= rx_byte;
			end
		end
	end

endmodule

### src/efpm_watchdog.sv
module efpm_watchdog import efpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  efpm_evt_t    ev,
	input  logic         frame_clr,
	input  logic [23:0]  timeout_ticks,
	input  logic [22:0]  blink_half_ticks,
	input  logic [7:0]   sync_blink_count,
	output efpm_status_t st
);

	logic [7:0]  sync_cnt_q;
	logic        led_q;
	logic [23:0] ticks_q;
	logic        fault_q;
	logic [23:0] phase_q;

	logic [23:0] ticks_inc;
	logic        entering;
	logic [24:0] phase_sum;
	logic [24:0] period;
	logic [23:0] phase_nxt;
	logic        fault_nxt;
	logic [8:0]  cnt_sum;

	assign ticks_inc = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 24'd1;
	assign entering  = (ticks_inc > timeout_ticks) && !fault_q;
	assign phase_sum = {1'b0, phase_q} + 25'd1;
	assign period    = {1'b0, blink_half_ticks, 1'b0};
	assign phase_nxt = (phase_sum >= period) ? 24'd0 : phase_sum[23:0];
	assign fault_nxt = fault_q | entering;
	assign cnt_sum   = {1'b0, sync_cnt_q} + 9'd1;

	assign st.led      = led_q;
	assign st.fault    = fault_q;
	assign st.entering = entering;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_cnt_q <= '0;
			led_q      <= 1'b1;
			ticks_q    <= '0;
			fault_q    <= 1'b0;
			phase_q    <= '0;
		end else if (ev.sync && frame_clr) begin
			ticks_q <= '0;
			fault_q <= 1'b0;
			if (cnt_sum >= {1'b0, sync_blink_count}) begin
				sync_cnt_q <= '0;
				led_q      <= ~led_q;
			end else begin
				sync_cnt_q <= cnt_sum[7:0];
			end
		end else if (ev.tick) begin
			ticks_q <= ticks_inc;
			phase_q <= phase_nxt;
			fault_q <= fault_nxt;
			if (fault_nxt) begin
				led_q <= (phase_nxt < {1'b0, blink_half_ticks});
			end
		end
	end

endmodule

### src/efpm_level_unit.sv
module efpm_level_unit import efpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         issue,
	input  efpm_issue_t  issue_data,
	output logic         issue_ready,
	input  logic [23:0]  counts_per_us_q16,
	input  logic [15:0]  wrap_level,
	input  logic         out_ready,
	output logic         out_valid,
	output logic [2:0]   motor_sel,
	output logic [15:0]  pulse_level,
	output logic         level_valid,
	output logic         led,
	output logic         fault,
	output logic         last
);

	// stage 1: width in microseconds
	logic             valid_s1;
	logic [10:0]      width_s1;
	efpm_issue_t      info_s1;

	// stage 2: output register
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      level_q;
	logic             lvl_valid_q;
	logic             led_q;
	logic             fault_q;
	logic             last_q;

	logic             advance;
	logic             move_s1;
	logic [34:0]      product;
	logic [18:0]      scaled;
	logic [15:0]      capped;
	logic [IDX_W+2:0] idx_ext;

	assign advance     = !out_valid_q || out_ready;
	assign move_s1     = valid_s1 && advance;
	assign issue_ready = !valid_s1 || advance;

	// the one multiplier: width times Q16 counts per microsecond
	assign product = 35'(width_s1) * 35'(counts_per_us_q16);
	assign scaled  = product[34:16];
	assign capped  = (scaled > 19'(wrap_level)) ? wrap_level : scaled[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue_ready) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && issue_ready) begin
			width_s1 <= value_to_width(issue_data.value);
			info_s1  <= issue_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			idx_q       <= info_s1.idx;
			level_q     <= info_s1.status ? 16'd0 : capped;
			lvl_valid_q <= !info_s1.status;
			led_q       <= info_s1.led;
			fault_q     <= info_s1.fault;
			last_q      <= info_s1.last;
		end
	end

	assign idx_ext     = (IDX_W + 3)'(idx_q);
	assign out_valid   = out_valid_q;
	assign motor_sel   = idx_ext[2:0];
	assign pulse_level = level_q;
	assign level_valid = lvl_valid_q;
	assign led         = led_q;
	assign fault       = fault_q;
	assign last        = last_q;

endmodule

### src/esc_frame_latch_pulse_mapper_unit.sv
// Frame byte: no result. Tick that does not enter the fault: one status
// result. Sync or fault entry: eight levels issued one a cycle while the
// mapper has room, into a two-stage mapper sharing one 11x24 multiplier;
// levels pass stage 1, then stage 2, the output register. arst_n clears all
// control, counters and stored bytes; registers return to their defaults, LED on.
module esc_frame_latch_pulse_mapper_unit import efpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  motor_sel,
	output logic [15:0] pulse_level,
	output logic        level_valid,
	output logic        led,
	output logic        fault,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// Sequencer modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_SYNC   = 2'd1;
	localparam logic [1:0] MODE_FAULT  = 2'd2;
	localparam logic [1:0] MODE_STATUS = 2'd3;

	// Configuration registers
	logic [2:0]  board_id_q;
	logic [23:0] counts_us_q;
	logic [15:0] wrap_level_q;
	logic [23:0] timeout_q;
	logic [22:0] blink_half_q;
	logic [7:0]  sync_blink_q;

	logic [1:0]       mode_q;
	logic [IDX_W-1:0] idx_q;

	logic         in_fire;
	logic         issue;
	logic         issue_ready;
	logic         issue_last;
	efpm_issue_t  issue_data;
	efpm_evt_t    ev;
	efpm_status_t st;
	logic [7:0]   rd_value;

	// Take a new beat only once every result of the previous one is issued
	assign in_ready = (mode_q == MODE_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign ev.sync = in_fire && (opcode == OP_SYNC);
	assign ev.tick = in_fire && (opcode == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_id_q   <= RST_BOARD_ID;
			counts_us_q  <= RST_COUNTS_US;
			wrap_level_q <= RST_WRAP_LEVEL;
			timeout_q    <= RST_TIMEOUT;
			blink_half_q <= RST_BLINK_HALF;
			sync_blink_q <= RST_SYNC_BLINK;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOARD_ID:   board_id_q   <= cfg_data[2:0];
				REG_COUNTS_US:  counts_us_q  <= cfg_data;
				REG_WRAP_LEVEL: wrap_level_q <= cfg_data[15:0];
				REG_TIMEOUT:    timeout_q    <= cfg_data;
				REG_BLINK_HALF: blink_half_q <= cfg_data[22:0];
				REG_SYNC_BLINK: sync_blink_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Frame position and the eight-byte window of this board; a sync
	// restarts the frame
	efpm_frame_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (ev.sync),
		.wr       (in_fire && (opcode == OP_BYTE)),
		.rx_byte  (rx_byte),
		.board_id (board_id_q),
		.rd_idx   (idx_q),
		.rd_value (rd_value)
	);

	// Sync counter, LED, watchdog and blink phase
	efpm_watchdog u_wdog (
		.clk              (clk),
		.arst_n           (arst_n),
		.ev               (ev),
		.frame_clr        (1'b1),
		.timeout_ticks    (timeout_q),
		.blink_half_ticks (blink_half_q),
		.sync_blink_count (sync_blink_q),
		.st               (st)
	);

	// Issue one result a cycle while the mapper has room. LED and fault are
	// sampled at issue, after the beat's state update has landed.
	assign issue      = (mode_q != MODE_IDLE) && issue_ready;
	assign issue_last = (mode_q == MODE_STATUS) || (idx_q == IDX_W'(MOTORS - 1));

	always_comb begin
		issue_data.idx    = idx_q;
		issue_data.value  = (mode_q == MODE_SYNC) ? rd_value : 8'd0;
		issue_data.status = (mode_q == MODE_STATUS);
		issue_data.led    = st.led;
		issue_data.fault  = st.fault;
		issue_data.last   = issue_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			idx_q  <= '0;
		end else if (in_fire) begin
			idx_q <= '0;
			case (opcode)
				OP_SYNC: mode_q <= MODE_SYNC;
				OP_TICK: mode_q <= st.entering ? MODE_FAULT : MODE_STATUS;
				default: mode_q <= MODE_IDLE;
			endcase
		end else if (issue) begin
			// drop back to idle after the final result, else advance the motor
			if (issue_last) begin
				mode_q <= MODE_IDLE;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	efpm_level_unit u_level (
		.clk               (clk),
		.arst_n            (arst_n),
		.issue             (issue),
		.issue_data        (issue_data),
		.issue_ready       (issue_ready),
		.counts_per_us_q16 (counts_us_q),
		.wrap_level        (wrap_level_q),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.motor_sel         (motor_sel),
		.pulse_level       (pulse_level),
		.level_valid       (level_valid),
		.led               (led),
		.fault             (fault),
		.last              (last)
	);

endmodule

### sim/esc_frame_latch_pulse_mapper_unit_tb.sv
`timescale 1ns / 100ps

module esc_frame_latch_pulse_mapper_unit_tb;
	import efpm_pkg::*;

	// Opcode that the block takes and drops without effect
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// Cycles to let pass before a register write once nothing is due: a frame
	// byte may still be in flight, and so may the end of a sync or fault entry
	localparam int SETTLE_CYCLES  = 12;
	// Cycles without any beat on either side before the run is declared hung
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 20;

	// One beat on the result side
	typedef struct packed {
		logic [2:0]  motor;
		logic [15:0] level;
		logic        valid;
		logic        led;
		logic        fault;
		logic        last;
	} level_beat_t;

	// Mirrors the mapper: its own copy of the registers and state, and a queue
	// of the result beats still owed by the block
	class level_scoreboard;
		logic [2:0]  board;
		logic [23:0] counts_us;
		logic [15:0] wrap;
		logic [23:0] timeout;
		logic [22:0] blink_half;
		logic [7:0]  sync_every;

		logic [6:0]  frame_pos;
		logic [7:0]  held [MOTORS];
		logic [7:0]  syncs_seen;
		logic        led_on;
		logic [23:0] since_sync;
		logic        faulted;
		logic [23:0] blink_ph;

		level_beat_t levels_due[$];
		int          errors;

		function new();
			board      = RST_BOARD_ID;
			counts_us  = RST_COUNTS_US;
			wrap       = RST_WRAP_LEVEL;
			timeout    = RST_TIMEOUT;
			blink_half = RST_BLINK_HALF;
			sync_every = RST_SYNC_BLINK;
			frame_pos  = '0;
			foreach (held[i]) held[i] = '0;
			syncs_seen = '0;
			led_on     = 1'b1;
			since_sync = '0;
			faulted    = 1'b0;
			blink_ph   = '0;
			errors     = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [23:0] data);
			case (idx)
				REG_BOARD_ID:   board      = data[2:0];
				REG_COUNTS_US:  counts_us  = data;
				REG_WRAP_LEVEL: wrap       = data[15:0];
				REG_TIMEOUT:    timeout    = data;
				REG_BLINK_HALF: blink_half = data[22:0];
				REG_SYNC_BLINK: sync_every = data[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return levels_due.size();
		endfunction

		// Widths stay within 1000..2000 by construction, so no clamp
		function logic [10:0] width_of(logic [7:0] v);
			if (v == 8'd0) return 11'd1000;
			return 11'd1200 + 11'((int'(v) * 800) / 255);
		endfunction

		function logic [15:0] level_of(logic [10:0] us);
			logic [34:0] prod;
			prod = (35'(us) * 35'(counts_us)) >> 16;
			return (prod > 35'(wrap)) ? wrap : prod[15:0];
		endfunction

		function void push_levels(logic idle_only);
			for (int i = 0; i < MOTORS; i++)
				levels_due.push_back('{motor: 3'(i),
					level: level_of(idle_only ? 11'd1000 : width_of(held[i])),
					valid: 1'b1, led: led_on, fault: faulted,
					last: (i == MOTORS - 1)});
		endfunction

		function void take_beat(logic [1:0] op, logic [7:0] b);
			int          pos;
			int          first;
			logic [8:0]  cnt;
			logic [24:0] ph_next;
			logic        entering;
			case (op)
				OP_BYTE: begin
					pos   = frame_pos;
					first = board * MOTORS;
					if (frame_pos < FRAME_LEN) frame_pos++;
					if (pos >= first && pos < first + MOTORS) held[pos - first] = b;
				end
				OP_SYNC: begin
					cnt = syncs_seen + 9'd1;
					if (cnt >= 9'(sync_every)) begin
						led_on = ~led_on;
						cnt    = '0;
					end
					syncs_seen = cnt[7:0];
					frame_pos  = '0;
					since_sync = '0;
					faulted    = 1'b0;
					push_levels(1'b0);
				end
				OP_TICK: begin
					ph_next  = blink_ph + 25'd1;
					blink_ph = (ph_next >= 25'({blink_half, 1'b0})) ? '0 : ph_next[23:0];
					if (since_sync != TICK_MAX) since_sync++;
					entering = (since_sync > timeout) && !faulted;
					if (entering) faulted = 1'b1;
					if (faulted) led_on = (blink_ph < 24'(blink_half));
					if (entering)
						push_levels(1'b1);
					else
						levels_due.push_back('{motor: 3'd0, level: 16'd0, valid: 1'b0,
							led: led_on, fault: faulted, last: 1'b1});
				end
				default: ;
			endcase
		endfunction

		function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_level(level_beat_t got);
			level_beat_t want;
			if (levels_due.size() == 0) begin
				$error("unexpected result beat: motor_sel %0d pulse_level %0d",
					got.motor, got.level);
				errors++;
				return;
			end
			want = levels_due.pop_front();
			cmp_field("motor_sel", 16'(want.motor), 16'(got.motor));
			cmp_field("pulse_level", want.level, got.level);
			cmp_field("level_valid", 16'(want.valid), 16'(got.valid));
			cmp_field("led", 16'(want.led), 16'(got.led));
			cmp_field("fault", 16'(want.fault), 16'(got.fault));
			cmp_field("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode      = OP_BYTE;
	logic [7:0]  rx_byte     = 8'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [2:0]  motor_sel;
	logic [15:0] pulse_level;
	logic        level_valid;
	logic        led;
	logic        fault;
	logic        last;
	logic        cfg_we      = 1'b0;
	logic [2:0]  cfg_index   = REG_BOARD_ID;
	logic [23:0] cfg_data    = 24'd0;

	level_scoreboard sb;
	// When set, neither side idles: the long stretch at full rate
	bit steady      = 1'b0;
	int quiet_cycles = 0;
	int sent;

	esc_frame_latch_pulse_mapper_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.motor_sel   (motor_sel),
		.pulse_level (pulse_level),
		.level_valid (level_valid),
		.led         (led),
		.fault       (fault),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor both channels at the rising edge, using the values that held
	// just before it; also drive the receiver's random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_level({motor_sel, pulse_level, level_valid, led, fault, last});
			if (in_valid && in_ready)
				sb.take_beat(opcode, rx_byte);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			out_ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// Hang detection: end the run if no beat moves for too long
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	// Offer one input beat and hold it until taken; idle first at random.
	// Valid is only lowered inside a gap, so a back-to-back beat keeps it high.
	task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
		while (!steady && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op != OP_RESERVED) sent++;
	endtask

	// Stop sending, wait for every owed result, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Write the whole register set while the block is idle
	task automatic apply_setting(input logic [2:0] board, input logic [23:0] cps,
			input logic [15:0] wrap, input logic [23:0] tmo,
			input logic [22:0] half, input logic [7:0] cnt);
		drain_results();
		write_reg(REG_BOARD_ID, 24'(board));
		write_reg(REG_COUNTS_US, cps);
		write_reg(REG_WRAP_LEVEL, 24'(wrap));
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_BLINK_HALF, 24'(half));
		write_reg(REG_SYNC_BLINK, 24'(cnt));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned first;
		int unsigned n;
		int unsigned ticks;
		int unsigned tmo;
		int          r;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults, board 0: fill the window with the byte extremes and
		// mixed bit patterns, latch them, then a tick, a reserved opcode, a
		// byte into a fresh frame and a second tick
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h01);
		send_beat(OP_BYTE, 8'h80);
		send_beat(OP_BYTE, 8'hFE);
		send_beat(OP_BYTE, 8'h55);
		send_beat(OP_BYTE, 8'hAA);
		send_beat(OP_BYTE, 8'h7F);
		send_beat(OP_SYNC, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_RESERVED, 8'hFF);
		send_beat(OP_BYTE, 8'h33);
		send_beat(OP_TICK, 8'h00);

		// Top of every range: levels hit the cap, a timeout of one trips
		// on the second tick, the fastest blink, an LED toggle on every sync
		apply_setting(3'd7, 24'hFFFFFF, 16'hFFFF, 24'd1, 23'd1, 8'd1);
		send_beat(OP_SYNC, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_SYNC, 8'h00);

		// Bottom of the scaling: zero factor and zero cap; a timeout that
		// never trips, the slowest blink and the rarest LED toggle
		apply_setting(3'd3, 24'd0, 16'd0, 24'hFFFFFF, 23'h7FFFFF, 8'd255);
		send_beat(OP_BYTE, 8'hC3);
		send_beat(OP_SYNC, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);

		// Random phases: mostly well-formed frames with random content, a run
		// of ticks (sometimes long enough to trip the watchdog) and a sync;
		// the rest is noise. Phase 1 runs with no idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			tmo = $urandom_range(1, 30);
			apply_setting(3'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
					: 24'($urandom_range(60000, 200000)),
				($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4000))
					: 16'($urandom_range(4000, 65535)),
				24'(tmo), 23'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
			steady = (ph == 1);
			sent   = 0;
			while (sent < PHASE_ITEMS) begin
				first = sb.board * MOTORS;
				if ($urandom_range(0, 9) < 7) begin
					// Usually stop inside or at the end of the window; now and
					// then run on past it, up to six bytes past the frame length
					n = ($urandom_range(0, 4) == 0)
						? $urandom_range(first + MOTORS, FRAME_LEN + 6)
						: $urandom_range(first + 1, first + MOTORS);
					repeat (n) begin
						r = $urandom_range(0, 9);
						send_beat(OP_BYTE, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF
							: 8'($urandom_range(0, 255)));
					end
					ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(tmo, tmo + 4)
						: $urandom_range(0, 3);
					repeat (ticks) send_beat(OP_TICK, 8'($urandom_range(0, 255)));
					send_beat(OP_SYNC, 8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 4))
						send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				end
			end
		end
		steady = 1'b0;

		drain_results();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
